// ===== hw/rtl/i2crr_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register read master package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package i2crr_pkg;

    localparam int MAX_READ_BYTES = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESTART_WAIT_TICKS = 1'd1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET     = 7'd40;
    localparam logic [20:0] RESTART_WAIT_TICKS_RESET = 21'd1250000;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [20:0] restart_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [7:0] register_address;
        logic [4:0] byte_count;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic       last;
        logic       busy_res;
    } result_t;

endpackage

// ===== hw/rtl/i2crr_if.sv =====
// ----------------------------------------------------------------------------
// I2C register read master channels
// Item, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface i2crr_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] register_address;
    logic [4:0] byte_count;
    logic       sda_in;

    modport source (output valid, output command, output register_address,
                    output byte_count, output sda_in, input ready);
    modport sink   (input valid, input command, input register_address,
                    input byte_count, input sda_in, output ready);
endinterface

interface i2crr_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last;
    logic       busy_res;

    modport source (output valid, output scl_level, output sda_level,
                    output sda_released, output byte_valid, output read_byte,
                    output last, output busy_res, input ready);
    modport sink   (input valid, input scl_level, input sda_level,
                    input sda_released, input byte_valid, input read_byte,
                    input last, input busy_res, output ready);
endinterface

interface i2crr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [i2crr_pkg::CFG_INDEX_W-1:0]  index;
    logic [i2crr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/i2crr_core.sv =====
// ----------------------------------------------------------------------------
// I2C register read sequencer
// Bus phase state and one quarter-bit step per accepted beat.
// ----------------------------------------------------------------------------
module i2crr_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  i2crr_pkg::item_t   item_in,
    input  i2crr_pkg::cfg_t    cfg_in,
    output i2crr_pkg::result_t result_out
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_WA   = 5'd3,
        PH_WR   = 5'd7,
        PH_RS   = 5'd11,
        PH_WB   = 5'd15,
        PH_WAIT = 5'd19,
        PH_RD   = 5'd20,
        PH_SP   = 5'd24
    } phase_t;

    localparam int MAX_READ_BYTES_I = i2crr_pkg::MAX_READ_BYTES;

    phase_t      phase_reg,       phase_next;
    logic [3:0]  bit_index_reg,   bit_index_next;
    logic [7:0]  shift_reg,       shift_next;
    logic [4:0]  bytes_left_reg,  bytes_left_next;
    logic [20:0] wait_reg,        wait_next;
    logic [7:0]  saved_reg,       saved_next;
    logic        scl_reg,         scl_next;
    logic        sda_reg,         sda_next;

    logic        rel;
    logic        byte_done;
    logic [7:0]  rbyte;
    logic        last_flag;
    logic [1:0]  q_w;
    logic [1:0]  q_r;
    logic [4:0]  wbase;
    logic [4:0]  cnt;
    logic [20:0] wait_dec;
    logic        data_bit;
    logic [4:0]  left_dec;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        wait_next       = wait_reg;
        saved_next      = saved_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        rel             = 1'b0;
        byte_done       = 1'b0;
        rbyte           = 8'd0;
        last_flag       = 1'b0;
        q_w             = 2'(phase_reg - PH_WA);
        q_r             = 2'(phase_reg);
        wbase           = phase_reg - {3'd0, q_w};
        cnt             = item_in.byte_count;
        wait_dec        = (wait_reg != 21'd0) ? wait_reg - 21'd1 : 21'd0;
        data_bit        = (bit_index_reg < 4'd8);
        left_dec        = (bytes_left_reg != 5'd0) ? bytes_left_reg - 5'd1 : 5'd0;

        if (step)
        begin
            if (item_in.command == i2crr_pkg::CMD_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (cnt == 5'd0)
                    begin
                        cnt = 5'd1;
                    end
                    if (32'(cnt) > MAX_READ_BYTES_I)
                    begin
                        cnt = 5'(MAX_READ_BYTES_I);
                    end
                    bytes_left_next = cnt;
                    saved_next      = item_in.register_address;
                    bit_index_next  = 4'd0;
                    shift_next      = 8'd0;
                    phase_next      = PH_ST0;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_IDLE;
            end
            else if (phase_reg == PH_ST0)
            begin
                sda_next   = 1'b0;
                phase_next = PH_ST1;
            end
            else if (phase_reg == PH_ST1)
            begin
                scl_next       = 1'b0;
                phase_next     = PH_WA;
                bit_index_next = 4'd0;
                shift_next     = {cfg_in.device_address, 1'b0};
            end
            else if (phase_reg >= PH_RS && phase_reg < PH_WB)
            begin
                case (q_w)
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
                if (q_w != 2'd3)
                begin
                    phase_next = phase_t'(phase_reg + 5'd1);
                end
                else
                begin
                    phase_next     = PH_WB;
                    bit_index_next = 4'd0;
                    shift_next     = {cfg_in.device_address, 1'b1};
                end
            end
            else if (phase_reg >= PH_WA && phase_reg < PH_WAIT)
            begin
                rel = !data_bit;
                case (q_w)
                    2'd0:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = rel ? 1'b1 : shift_reg[3'(4'd7 - bit_index_reg)];
                        phase_next = phase_t'(wbase + 5'd1);
                    end
                    2'd1, 2'd2:
                    begin
                        scl_next   = 1'b1;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        if (data_bit)
                        begin
                            bit_index_next = 4'(bit_index_reg + 4'd1);
                            phase_next     = phase_t'(wbase);
                        end
                        else if (wbase == PH_WA)
                        begin
                            phase_next     = PH_WR;
                            bit_index_next = 4'd0;
                            shift_next     = saved_reg;
                        end
                        else if (wbase == PH_WR)
                        begin
                            phase_next = PH_RS;
                        end
                        else if (cfg_in.restart_wait_ticks == 21'd0)
                        begin
                            phase_next     = PH_RD;
                            bit_index_next = 4'd0;
                            shift_next     = 8'd0;
                        end
                        else
                        begin
                            wait_next  = cfg_in.restart_wait_ticks;
                            phase_next = PH_WAIT;
                        end
                    end
                endcase
            end
            else if (phase_reg == PH_WAIT)
            begin
                wait_next = wait_dec;
                if (wait_dec == 21'd0)
                begin
                    phase_next     = PH_RD;
                    bit_index_next = 4'd0;
                    shift_next     = 8'd0;
                end
            end
            else if (phase_reg >= PH_RD && phase_reg < PH_SP)
            begin
                rel = data_bit;
                case (q_r)
                    2'd0:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = data_bit ? 1'b1 : (bytes_left_reg <= 5'd1);
                        phase_next = phase_t'(PH_RD + 5'd1);
                    end
                    2'd1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = phase_t'(PH_RD + 5'd2);
                    end
                    2'd2:
                    begin
                        scl_next = 1'b1;
                        if (data_bit)
                        begin
                            shift_next = {shift_reg[6:0], item_in.sda_in};
                            if (bit_index_reg == 4'd7)
                            begin
                                byte_done = 1'b1;
                                rbyte     = shift_next;
                                last_flag = (bytes_left_reg <= 5'd1);
                            end
                        end
                        phase_next = phase_t'(PH_RD + 5'd3);
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        if (data_bit)
                        begin
                            bit_index_next = 4'(bit_index_reg + 4'd1);
                            phase_next     = PH_RD;
                        end
                        else
                        begin
                            bytes_left_next = left_dec;
                            if (left_dec == 5'd0)
                            begin
                                phase_next = PH_SP;
                            end
                            else
                            begin
                                phase_next     = PH_RD;
                                bit_index_next = 4'd0;
                                shift_next     = 8'd0;
                            end
                        end
                    end
                endcase
            end
            else if (phase_reg >= PH_SP && phase_reg < 5'(PH_SP + 5'd3))
            begin
                case (q_r)
                    2'd0:
                    begin
                        sda_next   = 1'b0;
                        phase_next = phase_t'(PH_SP + 5'd1);
                    end
                    2'd1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = phase_t'(PH_SP + 5'd2);
                    end
                    default:
                    begin
                        sda_next       = 1'b1;
                        phase_next     = PH_IDLE;
                        bit_index_next = 4'd0;
                    end
                endcase
            end
            else
            begin
                // drop out of an unknown phase
                phase_next      = PH_IDLE;
                scl_next        = 1'b1;
                sda_next        = 1'b1;
                bit_index_next  = 4'd0;
                bytes_left_next = 5'd0;
            end
        end

        result_out.scl_level    = scl_next;
        result_out.sda_level    = rel | sda_next;
        result_out.sda_released = rel;
        result_out.byte_valid   = byte_done;
        result_out.read_byte    = rbyte;
        result_out.last         = last_flag;
        result_out.busy_res     = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 5'd0;
            wait_reg       <= 21'd0;
            saved_reg      <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            wait_reg       <= wait_next;
            saved_reg      <= saved_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

endmodule

// ===== hw/rtl/i2c_master_register_read.sv =====
// ----------------------------------------------------------------------------
// I2C master register read
// Bit-level I2C master that reads a run of bytes from one target register,
// one quarter-bit bus phase per tick beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat payload
//  item     in   command, register_address, byte_count, sda_in
//  result   out  scl_level, sda_level, sda_released, byte_valid, read_byte,
//                last, busy_res
//  cfg      in   index, data (device_address, restart_wait_ticks)
//
//  One item beat per clock unless the item channel stalls; each item beat yields
//  one result beat in the following cycle through the result register.
//  The sequencer step is a single pass of logic between the state and the
//  result register.
//  The item channel stalls only while the result register is full and not
//  being taken. cfg is always ready.
//  Reset: idle, both lines high, cfg registers at their default values; result_reg is not reset.
// ----------------------------------------------------------------------------
module i2c_master_register_read
(
    input  logic            clk,
    input  logic            rst_n,
    i2crr_item_if.sink      item,
    i2crr_result_if.source  result,
    i2crr_cfg_if.sink       cfg
);

    i2crr_pkg::cfg_t    cfg_reg;
    i2crr_pkg::item_t   item_in;
    i2crr_pkg::result_t step_result;
    i2crr_pkg::result_t result_reg;
    logic               out_valid_reg;
    logic               item_accept;

    assign item.ready  = !out_valid_reg || result.ready;
    assign item_accept = item.valid && item.ready;
    assign cfg.ready   = 1'b1;

    assign item_in.command          = item.command;
    assign item_in.register_address = item.register_address;
    assign item_in.byte_count       = item.byte_count;
    assign item_in.sda_in           = item.sda_in;

    i2crr_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (item_accept),
        .item_in    (item_in),
        .cfg_in     (cfg_reg),
        .result_out (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address     <= i2crr_pkg::DEVICE_ADDRESS_RESET;
            cfg_reg.restart_wait_ticks <= i2crr_pkg::RESTART_WAIT_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                i2crr_pkg::REG_DEVICE_ADDRESS:
                    cfg_reg.device_address <= cfg.data[6:0];
                i2crr_pkg::REG_RESTART_WAIT_TICKS:
                    cfg_reg.restart_wait_ticks <= cfg.data[20:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            result_reg <= step_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.scl_level    = result_reg.scl_level;
    assign result.sda_level    = result_reg.sda_level;
    assign result.sda_released = result_reg.sda_released;
    assign result.byte_valid   = result_reg.byte_valid;
    assign result.read_byte    = result_reg.read_byte;
    assign result.last         = result_reg.last;
    assign result.busy_res     = result_reg.busy_res;

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> out_valid_reg)
        else $error("item beat did not load the result register");

    a_byte_while_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.byte_valid |-> result_reg.sda_released)
        else $error("byte completed while SDA driven");

    a_last_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.last |-> result_reg.byte_valid)
        else $error("last mark without a byte");

    a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.busy_res |-> result_reg.scl_level && result_reg.sda_level)
        else $error("bus lines not released while idle");

endmodule
